// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the rectangle fill sequencer RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define LRF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrf assertion failed");

// Check that the consequent holds in the cycle after the antecedent
`define LRF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrf assertion failed");

`endif

// File: rtl/lrf_pkg.sv
// ---------------------------------------------------------------------------
// lrf_pkg
// Shared constants, command codes and types of the rectangle fill sequencer.
// ---------------------------------------------------------------------------
package lrf_pkg;

  localparam int COORD_BITS    = 12;
  localparam int CALC_BITS     = COORD_BITS + 2;
  localparam int SCR_BITS      = 11;
  localparam int PIX_BITS      = 2 * SCR_BITS;
  localparam int COLOR_BITS    = 16;
  localparam int Q_DEPTH       = 4;
  localparam int Q_PTR_BITS    = $clog2(Q_DEPTH);
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  localparam logic [7:0] CMD_COLUMN = 8'h2A;
  localparam logic [7:0] CMD_ROW    = 8'h2B;
  localparam logic [7:0] CMD_WRITE  = 8'h2C;

  localparam logic [SCR_BITS-1:0] SCREEN_W_RST = SCR_BITS'(320);
  localparam logic [SCR_BITS-1:0] SCREEN_H_RST = SCR_BITS'(240);

  // Item actions
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_PULL  = 1'b1;

  // Register indexes (address bit 2)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Position in the byte stream of one fill
  typedef enum logic [3:0] {
    HS_COL_CMD,
    HS_COL_SH,
    HS_COL_SL,
    HS_COL_EH,
    HS_COL_EL,
    HS_ROW_CMD,
    HS_ROW_SH,
    HS_ROW_SL,
    HS_ROW_EH,
    HS_ROW_EL,
    HS_WRITE_CMD,
    HS_PIXEL
  } hdr_step_t;

  // Classified item travelling from front to back
  typedef struct packed {
    logic                  is_pull;
    logic [SCR_BITS-1:0]   col_start;
    logic [SCR_BITS-1:0]   col_end;
    logic [SCR_BITS-1:0]   row_start;
    logic [SCR_BITS-1:0]   row_end;
    logic [SCR_BITS-1:0]   span_w;
    logic [SCR_BITS-1:0]   span_h;
    logic [COLOR_BITS-1:0] color;
  } lrf_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lrf_qstat_t;

endpackage

// File: rtl/lrf_front.sv
// ---------------------------------------------------------------------------
// lrf_front
// Classifies incoming items and clips start rectangles to the screen; starts
// that clip to nothing are dropped here and never reach the queue.
// ---------------------------------------------------------------------------
module lrf_front (
  input  logic                                  action,
  input  logic signed [lrf_pkg::COORD_BITS-1:0] rect_x,
  input  logic signed [lrf_pkg::COORD_BITS-1:0] rect_y,
  input  logic signed [lrf_pkg::COORD_BITS-1:0] rect_w,
  input  logic signed [lrf_pkg::COORD_BITS-1:0] rect_h,
  input  logic [lrf_pkg::COLOR_BITS-1:0]        color,
  input  logic [lrf_pkg::SCR_BITS-1:0]          screen_width,
  input  logic [lrf_pkg::SCR_BITS-1:0]          screen_height,
  output logic                                  keep,
  output lrf_pkg::lrf_cmd_t                     cmd
);
  import lrf_pkg::*;

  logic signed [CALC_BITS-1:0] x, y, w, h, sw, sh;
  logic signed [CALC_BITS-1:0] x0, y0, w0, h0, w1, h1;
  logic signed [CALC_BITS-1:0] x_end, y_end, c_end, r_end;
  logic                        x_over, y_over, clip_empty;

  // Widen to a range that holds every sum
  assign x  = CALC_BITS'(rect_x);
  assign y  = CALC_BITS'(rect_y);
  assign w  = CALC_BITS'(rect_w);
  assign h  = CALC_BITS'(rect_h);
  assign sw = $signed(CALC_BITS'(screen_width));
  assign sh = $signed(CALC_BITS'(screen_height));

  // Clip the left and top edges
  assign x0 = (x < 0) ? '0 : x;
  assign y0 = (y < 0) ? '0 : y;
  assign w0 = (x < 0) ? w + x : w;
  assign h0 = (y < 0) ? h + y : h;

  // Clip the right and bottom edges; the far edge is unchanged by the left clip
  assign x_end  = x + w;
  assign y_end  = y + h;
  assign x_over = x_end > sw;
  assign y_over = y_end > sh;
  assign w1     = x_over ? sw - x0 : w0;
  assign h1     = y_over ? sh - y0 : h0;
  assign c_end  = x_over ? sw - CALC_BITS'(1) : x_end - CALC_BITS'(1);
  assign r_end  = y_over ? sh - CALC_BITS'(1) : y_end - CALC_BITS'(1);

  assign clip_empty = (w1 <= 0) || (h1 <= 0);

  // Pulls always go on; starts only when something is left to draw
  assign keep = (action == ACT_PULL) || !clip_empty;

  always_comb begin
    cmd.is_pull   = (action == ACT_PULL);
    cmd.col_start = x0[SCR_BITS-1:0];
    cmd.col_end   = c_end[SCR_BITS-1:0];
    cmd.row_start = y0[SCR_BITS-1:0];
    cmd.row_end   = r_end[SCR_BITS-1:0];
    cmd.span_w    = w1[SCR_BITS-1:0];
    cmd.span_h    = h1[SCR_BITS-1:0];
    cmd.color     = color;
  end

endmodule

// File: rtl/lrf_queue.sv
// ---------------------------------------------------------------------------
// lrf_queue
// Short first-in first-out queue of classified items between front and back.
// ---------------------------------------------------------------------------
module lrf_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lrf_pkg::lrf_cmd_t  push_cmd,
  input  logic               pop,
  output lrf_pkg::lrf_cmd_t  head,
  output lrf_pkg::lrf_qstat_t stat
);
  import lrf_pkg::*;

  lrf_cmd_t              store [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [Q_PTR_BITS:0]   count;

  assign stat.full  = (count == (Q_PTR_BITS+1)'(Q_DEPTH));
  assign stat.empty = (count == '0);
  assign head       = store[rd_ptr];

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/lrf_back.sv
// ---------------------------------------------------------------------------
// lrf_back
// Carries out queued items in order: loads a fill window on a start while idle,
// walks the command header and pixel bytes on each pull, and holds the result
// in an output register.
// ---------------------------------------------------------------------------
module lrf_back (
  input  logic              clk,
  input  logic              rst,
  input  lrf_pkg::lrf_cmd_t head,
  input  logic              q_empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              has_byte,
  output logic [7:0]        out_byte,
  output logic              is_data,
  output logic              last
);
  import lrf_pkg::*;

  logic                  busy, busy_next;
  hdr_step_t             step, step_next;
  logic [SCR_BITS-1:0]   col_start, col_end, row_start, row_end;
  logic [SCR_BITS-1:0]   col_start_next, col_end_next, row_start_next, row_end_next;
  logic [COLOR_BITS-1:0] fill_color, fill_color_next;
  logic [PIX_BITS-1:0]   pixels_left, pixels_left_next;
  logic                  high_next, high_next_next;
  logic                  out_valid_next;
  logic                  emit;
  logic                  e_has, e_data, e_last;
  logic [7:0]            e_byte;
  logic                  can_emit;

  // Take the head when it is a start, or when the output register is free
  assign can_emit = !out_valid || out_ready;
  assign pop      = !q_empty && (!head.is_pull || can_emit);

  // Next state and byte selection
  always_comb begin
    busy_next        = busy;
    step_next        = step;
    col_start_next   = col_start;
    col_end_next     = col_end;
    row_start_next   = row_start;
    row_end_next     = row_end;
    fill_color_next  = fill_color;
    pixels_left_next = pixels_left;
    high_next_next   = high_next;
    out_valid_next   = out_valid && !out_ready;
    emit             = 1'b0;
    e_has            = 1'b0;
    e_byte           = '0;
    e_data           = 1'b0;
    e_last           = 1'b0;

    if (pop) begin
      if (!head.is_pull) begin
        // Load a new window unless a fill is running
        if (!busy) begin
          busy_next        = 1'b1;
          step_next        = HS_COL_CMD;
          high_next_next   = 1'b1;
          col_start_next   = head.col_start;
          col_end_next     = head.col_end;
          row_start_next   = head.row_start;
          row_end_next     = head.row_end;
          fill_color_next  = head.color;
          pixels_left_next = PIX_BITS'(head.span_w) * PIX_BITS'(head.span_h);
        end
      end else begin
        emit           = 1'b1;
        out_valid_next = 1'b1;
        if (busy) begin
          e_has  = 1'b1;
          e_data = 1'b1;
          if (step != HS_PIXEL) begin
            step_next = hdr_step_t'(step + 4'd1);
          end
          case (step)
            HS_COL_CMD: begin
              e_byte = CMD_COLUMN;
              e_data = 1'b0;
            end
            HS_COL_SH: e_byte = 8'(col_start >> 8);
            HS_COL_SL: e_byte = col_start[7:0];
            HS_COL_EH: e_byte = 8'(col_end >> 8);
            HS_COL_EL: e_byte = col_end[7:0];
            HS_ROW_CMD: begin
              e_byte = CMD_ROW;
              e_data = 1'b0;
            end
            HS_ROW_SH: e_byte = 8'(row_start >> 8);
            HS_ROW_SL: e_byte = row_start[7:0];
            HS_ROW_EH: e_byte = 8'(row_end >> 8);
            HS_ROW_EL: e_byte = row_end[7:0];
            HS_WRITE_CMD: begin
              e_byte = CMD_WRITE;
              e_data = 1'b0;
            end
            HS_PIXEL: begin
              // Colour high byte, then low byte closes one pixel
              if (high_next) begin
                e_byte         = fill_color[15:8];
                high_next_next = 1'b0;
              end else begin
                e_byte           = fill_color[7:0];
                high_next_next   = 1'b1;
                pixels_left_next = pixels_left - 1'b1;
                if (pixels_left == PIX_BITS'(1)) begin
                  e_last    = 1'b1;
                  busy_next = 1'b0;
                  step_next = HS_COL_CMD;
                end
              end
            end
            default: e_byte = '0;
          endcase
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= HS_COL_CMD;
      high_next <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      step      <= step_next;
      high_next <= high_next_next;
      out_valid <= out_valid_next;
    end
  end

  // Window and pixel counter
  always_ff @(posedge clk) begin
    col_start   <= col_start_next;
    col_end     <= col_end_next;
    row_start   <= row_start_next;
    row_end     <= row_end_next;
    fill_color  <= fill_color_next;
    pixels_left <= pixels_left_next;
  end

  // Output register; hold while the result waits
  always_ff @(posedge clk) begin
    if (emit) begin
      has_byte <= e_has;
      out_byte <= e_byte;
      is_data  <= e_data;
      last     <= e_last;
    end
  end

endmodule

// File: rtl/lcd_rectangle_fill_sequencer_top.sv
// ---------------------------------------------------------------------------
// lcd_rectangle_fill_sequencer_top
// Rectangle fill byte sequencer for a serial LCD panel, with screen size
// registers on an APB-style port.
// ---------------------------------------------------------------------------
// The block takes one item per clock while the queue has room. A start item
// (action 0) is clipped to the screen in the cycle it is accepted and, if
// anything is left, queued; a start that clips to nothing is dropped and a
// start that reaches the back end while a fill runs is ignored, and neither
// gives a result. A pull item (action 1) gives exactly one result: the next
// panel byte (column command and four address bytes, row command and four
// bytes, memory-write command, then two bytes per pixel, the final one with
// last set), or has_byte 0 when no fill runs. A four-entry queue sits between
// the clipping front end and the byte sequencer, and the back end retires one
// queued item per cycle, pulls only while its output register is free or
// being taken; a pull passes through the queue and then the output register,
// and pulls sustain one byte per cycle while out_ready stays high. Registers
// screen_width (address 0) and screen_height (address 4) reset to 320 and 240.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lcd_rectangle_fill_sequencer_top (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     action,
  input  logic signed [lrf_pkg::COORD_BITS-1:0]    rect_x,
  input  logic signed [lrf_pkg::COORD_BITS-1:0]    rect_y,
  input  logic signed [lrf_pkg::COORD_BITS-1:0]    rect_w,
  input  logic signed [lrf_pkg::COORD_BITS-1:0]    rect_h,
  input  logic [lrf_pkg::COLOR_BITS-1:0]           color,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic                                     has_byte,
  output logic [7:0]                               out_byte,
  output logic                                     is_data,
  output logic                                     last,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [lrf_pkg::APB_ADDR_BITS-1:0]        paddr,
  input  logic [lrf_pkg::APB_DATA_BITS-1:0]        pwdata,
  output logic [lrf_pkg::APB_DATA_BITS-1:0]        prdata,
  output logic                                     pready
);
  import lrf_pkg::*;

  logic [SCR_BITS-1:0] screen_width, screen_height;
  logic                cfg_write;
  logic                keep, push, pop;
  lrf_cmd_t            front_cmd, q_head;
  lrf_qstat_t          q_stat;

  // Register port: always ready, written in the access phase
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_W_RST;
      screen_height <= SCREEN_H_RST;
    end else if (cfg_write) begin
      if (paddr[2] == REG_WIDTH) begin
        screen_width <= pwdata[SCR_BITS-1:0];
      end else begin
        screen_height <= pwdata[SCR_BITS-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? APB_DATA_BITS'(screen_height)
                                           : APB_DATA_BITS'(screen_width);

  // Accept while the queue has room
  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready && keep;

  lrf_front u_front (
    .action        (action),
    .rect_x        (rect_x),
    .rect_y        (rect_y),
    .rect_w        (rect_w),
    .rect_h        (rect_h),
    .color         (color),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .keep          (keep),
    .cmd           (front_cmd)
  );

  lrf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  lrf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_empty   (q_stat.empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .has_byte  (has_byte),
    .out_byte  (out_byte),
    .is_data   (is_data),
    .last      (last)
  );

  // An accepted pull is waiting in the queue in the following cycle
  `LRF_ASSERT_NEXT(a_pull_queued, clk, rst, in_valid && in_ready && (action == ACT_PULL), !q_stat.empty)
  // The closing byte of a fill is always a real pixel byte
  `LRF_ASSERT_SAME(a_last_is_pixel, clk, rst, out_valid && last, has_byte && is_data)
  // An idle pull result carries nothing
  `LRF_ASSERT_SAME(a_idle_blank, clk, rst, out_valid && !has_byte, (out_byte == 8'h00) && !is_data && !last)

endmodule

// File: test/lcd_fill_byte_checker.sv
// ---------------------------------------------------------------------------
// lcd_fill_byte_checker
// Watches the item, result and register channels of the rectangle fill
// sequencer. Keeps its own copy of the screen size and of the fill state,
// works out the panel byte each accepted pull should give and compares every
// accepted result with the oldest byte waiting. Register reads are checked
// against the copy of the registers.
// ---------------------------------------------------------------------------
module lcd_fill_byte_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic                                  action,
  input  logic signed [lrf_pkg::COORD_BITS-1:0] rect_x,
  input  logic signed [lrf_pkg::COORD_BITS-1:0] rect_y,
  input  logic signed [lrf_pkg::COORD_BITS-1:0] rect_w,
  input  logic signed [lrf_pkg::COORD_BITS-1:0] rect_h,
  input  logic [lrf_pkg::COLOR_BITS-1:0]        color,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic                                  has_byte,
  input  logic [7:0]                            out_byte,
  input  logic                                  is_data,
  input  logic                                  last,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic                                  pready,
  input  logic [lrf_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  logic [lrf_pkg::APB_DATA_BITS-1:0]     pwdata,
  input  logic [lrf_pkg::APB_DATA_BITS-1:0]     prdata,
  output int                                    fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import lrf_pkg::*;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] value;
    logic       is_data;
    logic       last_byte;
  } panel_byte_t;

  panel_byte_t           byte_queue[$];
  logic [SCR_BITS-1:0]   scr_w;
  logic [SCR_BITS-1:0]   scr_h;
  logic                  fill_busy;
  hdr_step_t             step;
  logic [SCR_BITS-1:0]   col_first;
  logic [SCR_BITS-1:0]   col_final;
  logic [SCR_BITS-1:0]   row_first;
  logic [SCR_BITS-1:0]   row_final;
  logic [COLOR_BITS-1:0] fill_colour;
  logic [PIX_BITS-1:0]   pixels_left;
  logic                  high_next;
  int                    mismatches = 0;
  int                    outstanding = 0;

  // Bytes still owed count as failures until they arrive
  assign fail_count = mismatches + outstanding;

  function automatic string show(input panel_byte_t b);
    return $sformatf("has_byte=%0b out_byte=%02h is_data=%0b last=%0b",
                     b.has_byte, b.value, b.is_data, b.last_byte);
  endfunction

  task automatic note_failure(input string what, input string want_s, input string got_s);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected %s, got %s", $realtime, what, want_s, got_s);
  endtask

  // Clip a start to the screen and, if anything is left, begin the fill
  task automatic clip_start(input logic signed [COORD_BITS-1:0] x, y, w, h,
                            input logic [COLOR_BITS-1:0] c);
    int cx, cy, cw, ch;
    cx = x;
    cy = y;
    cw = w;
    ch = h;
    if (cx < 0) begin
      cw += cx;
      cx = 0;
    end
    if (cy < 0) begin
      ch += cy;
      cy = 0;
    end
    if (cx + cw > int'(scr_w)) cw = int'(scr_w) - cx;
    if (cy + ch > int'(scr_h)) ch = int'(scr_h) - cy;
    if (cw <= 0 || ch <= 0) return;
    col_first   = SCR_BITS'(cx);
    col_final   = SCR_BITS'(cx + cw - 1);
    row_first   = SCR_BITS'(cy);
    row_final   = SCR_BITS'(cy + ch - 1);
    pixels_left = PIX_BITS'(cw * ch);
    fill_colour = c;
    step        = HS_COL_CMD;
    high_next   = 1'b1;
    fill_busy   = 1'b1;
  endtask

  // Work out the byte a pull gives and advance the fill
  task automatic next_byte(output panel_byte_t e);
    e = '0;
    if (!fill_busy) return;
    e.has_byte = 1'b1;
    e.is_data  = 1'b1;
    if (step != HS_PIXEL) begin
      case (step)
        HS_COL_CMD: begin
          e.value   = CMD_COLUMN;
          e.is_data = 1'b0;
        end
        HS_COL_SH: e.value = 8'(col_first >> 8);
        HS_COL_SL: e.value = col_first[7:0];
        HS_COL_EH: e.value = 8'(col_final >> 8);
        HS_COL_EL: e.value = col_final[7:0];
        HS_ROW_CMD: begin
          e.value   = CMD_ROW;
          e.is_data = 1'b0;
        end
        HS_ROW_SH: e.value = 8'(row_first >> 8);
        HS_ROW_SL: e.value = row_first[7:0];
        HS_ROW_EH: e.value = 8'(row_final >> 8);
        HS_ROW_EL: e.value = row_final[7:0];
        default: begin
          e.value   = CMD_WRITE;
          e.is_data = 1'b0;
        end
      endcase
      step = hdr_step_t'(step + 1);
    end else if (high_next) begin
      e.value   = fill_colour[15:8];
      high_next = 1'b0;
    end else begin
      e.value     = fill_colour[7:0];
      high_next   = 1'b1;
      pixels_left = pixels_left - 1'b1;
      if (pixels_left == '0) begin
        e.last_byte = 1'b1;
        fill_busy   = 1'b0;
        step        = HS_COL_CMD;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    panel_byte_t             want;
    panel_byte_t             got;
    logic [APB_DATA_BITS-1:0] reg_value;
    if (rst) begin
      scr_w       = SCREEN_W_RST;
      scr_h       = SCREEN_H_RST;
      fill_busy   = 1'b0;
      step        = HS_COL_CMD;
      col_first   = '0;
      col_final   = '0;
      row_first   = '0;
      row_final   = '0;
      fill_colour = '0;
      pixels_left = '0;
      high_next   = 1'b1;
      byte_queue.delete();
      outstanding = 0;
    end else begin
      // Compare a delivered byte with the oldest one owed
      if (out_valid && out_ready) begin
        got = '{has_byte, out_byte, is_data, last};
        if (byte_queue.size() == 0) begin
          note_failure("unexpected result", "nothing", show(got));
        end else begin
          want = byte_queue.pop_front();
          outstanding--;
          if (got !== want) note_failure("wrong result", show(want), show(got));
        end
      end
      // Track register writes, check reads
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_WIDTH) scr_w = pwdata[SCR_BITS-1:0];
          else scr_h = pwdata[SCR_BITS-1:0];
        end else begin
          reg_value = (paddr[2] == REG_WIDTH) ? APB_DATA_BITS'(scr_w) : APB_DATA_BITS'(scr_h);
          if (prdata !== reg_value)
            note_failure($sformatf("register read at %0d", paddr),
                         $sformatf("%08h", reg_value), $sformatf("%08h", prdata));
        end
      end
      // Take an accepted item
      if (in_valid && in_ready) begin
        if (action == ACT_START) begin
          if (!fill_busy) clip_start(rect_x, rect_y, rect_w, rect_h, color);
        end else begin
          next_byte(want);
          byte_queue.push_back(want);
          outstanding++;
        end
      end
    end
  end

endmodule

// File: test/lcd_rectangle_fill_sequencer_top_test.sv
// ---------------------------------------------------------------------------
// lcd_rectangle_fill_sequencer_top_test
// Drives rectangle fills through the sequencer: a directed set of clipping
// corners and screen sizes, then random fills under changing screen sizes
// and idling patterns. A fill is a start, then pulls until it ends or a cap
// is reached. The checker beside the block predicts and compares every byte.
// ---------------------------------------------------------------------------
module lcd_rectangle_fill_sequencer_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lrf_pkg::*;

  localparam int RESET_CYCLES  = 6;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 240;
  localparam int NO_CAP        = 1 << 30;
  localparam int NOISE_AREA    = 1200;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         action = ACT_PULL;
  logic signed [COORD_BITS-1:0] rect_x = '0;
  logic signed [COORD_BITS-1:0] rect_y = '0;
  logic signed [COORD_BITS-1:0] rect_w = '0;
  logic signed [COORD_BITS-1:0] rect_h = '0;
  logic [COLOR_BITS-1:0]        color = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         has_byte;
  logic [7:0]                   out_byte;
  logic                         is_data;
  logic                         last;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0]     paddr = '0;
  logic [APB_DATA_BITS-1:0]     pwdata = '0;
  logic [APB_DATA_BITS-1:0]     prdata;
  logic                         pready;
  int                           fail_count;

  int items_sent = 0;
  int pulls_sent = 0;
  int bytes_seen = 0;
  int ends_seen = 0;
  int send_idle_pct = 13;
  int recv_stall_pct = 47;
  int scr_w = 320;
  int scr_h = 240;
  bit allow_noise = 1'b0;
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;

  lcd_rectangle_fill_sequencer_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .rect_x(rect_x), .rect_y(rect_y), .rect_w(rect_w), .rect_h(rect_h), .color(color),
    .out_valid(out_valid), .out_ready(out_ready), .has_byte(has_byte),
    .out_byte(out_byte), .is_data(is_data), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lcd_fill_byte_checker byte_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .rect_x(rect_x), .rect_y(rect_y), .rect_w(rect_w), .rect_h(rect_h), .color(color),
    .out_valid(out_valid), .out_ready(out_ready), .has_byte(has_byte),
    .out_byte(out_byte), .is_data(is_data), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .fail_count(fail_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Count handshakes to pace the stimulus
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      items_sent <= items_sent + 1;
      if (action == ACT_PULL) pulls_sent <= pulls_sent + 1;
    end
    if (out_valid && out_ready) begin
      bytes_seen <= bytes_seen + 1;
      if (last || !has_byte) ends_seen <= ends_seen + 1;
    end
  end

  // Receiver: random stalls, and a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        repeat (HOLD_CYCLES) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
        hold_ack <= hold_req;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Give up after a generous number of cycles
  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input logic act, input logic [COORD_BITS-1:0] x, y, w, h,
                           input logic [COLOR_BITS-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    rect_x   <= x;
    rect_y   <= y;
    rect_w   <= w;
    rect_h   <= h;
    color    <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop offering and wait for every pull to come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_seen < pulls_sent) @(posedge clk);
  endtask

  // One fill: a start, then pulls until the fill ends or the cap is reached
  task automatic run_fill(input logic [COORD_BITS-1:0] x, y, w, h,
                          input logic [COLOR_BITS-1:0] c, input int cap);
    int mark;
    int n;
    drain();
    mark = ends_seen;
    send_item(ACT_START, x, y, w, h, c);
    n = 0;
    while (ends_seen == mark && n < cap) begin
      // drop in a stray start now and then; the block ignores it while a fill runs
      if (allow_noise && n == 4 && $urandom_range(3) == 0)
        send_item(ACT_START, COORD_BITS'($urandom), COORD_BITS'($urandom),
                  COORD_BITS'($urandom), COORD_BITS'($urandom), COLOR_BITS'($urandom));
      send_item(ACT_PULL, COORD_BITS'($urandom), COORD_BITS'($urandom),
                COORD_BITS'($urandom), COORD_BITS'($urandom), COLOR_BITS'($urandom));
      n++;
    end
  endtask

  task automatic reg_access(input logic wr, input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write a screen size while idle, with junk above the register, then read it
  task automatic set_screen(input logic idx, input int value);
    logic [31:0] junk;
    junk = $urandom;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    reg_access(1'b1, idx, {junk[31:SCR_BITS], value[SCR_BITS-1:0]});
    reg_access(1'b0, idx, junk);
    if (idx == REG_WIDTH) scr_w = value;
    else scr_h = value;
  endtask

  // Position and size along one axis; the clipped span never exceeds six
  task automatic pick_span(input int screen, output logic [COORD_BITS-1:0] pos, span);
    case ($urandom_range(9))
      0: begin
        pos = COORD_BITS'($urandom);
        span = COORD_BITS'($urandom);
        span[COORD_BITS-1] = 1'b1;
      end
      1: begin
        pos  = COORD_BITS'(screen - int'($urandom_range(1, 6)));
        span = COORD_BITS'(2047 - int'($urandom_range(0, 15)));
      end
      2: begin
        pos  = COORD_BITS'($urandom);
        span = COORD_BITS'($urandom_range(0, 6));
      end
      default: begin
        pos  = COORD_BITS'(int'($urandom_range(0, screen + 3)) - 4);
        span = COORD_BITS'($urandom_range(1, 6));
      end
    endcase
  endtask

  task automatic random_fill();
    logic [COORD_BITS-1:0] x, y, w, h;
    pick_span(scr_w, x, w);
    pick_span(scr_h, y, h);
    run_fill(x, y, w, h, COLOR_BITS'($urandom),
             ($urandom_range(99) < 15) ? int'($urandom_range(1, 20)) : NO_CAP);
  endtask

  initial begin : stimulus
    int idle_send[3];
    int idle_recv[3];
    int base;
    int p;
    int sw;
    int sh;
    idle_send = '{13, 47, 0};
    idle_recv = '{47, 13, 0};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Clipping corners at the reset screen size
    run_fill(0, 0, 0, 5, 16'h1234, NO_CAP);
    run_fill(-2048, -2048, 2047, 2047, 16'hFFFF, NO_CAP);
    run_fill(318, 238, 2047, 2047, 16'hFFFF, 5);
    run_fill(0, 0, 5, 5, 16'h0000, NO_CAP);
    run_fill(-3, -1, 4, 2, 16'h0000, NO_CAP);
    run_fill(316, 100, 2047, 1, 16'hA5C3, 3);
    run_fill(10, 10, 3, 3, 16'h5A3C, NO_CAP);
    run_fill(320, 0, 5, 5, 16'h00FF, NO_CAP);
    run_fill(0, 240, 5, 5, 16'hFF00, NO_CAP);
    run_fill(0, 0, 5, -2048, 16'h8421, NO_CAP);

    // Largest screen, corner of the address range
    set_screen(REG_WIDTH, 2047);
    set_screen(REG_HEIGHT, 2047);
    run_fill(2044, 2040, 100, 100, 16'h07E0, NO_CAP);
    run_fill(2047, 2047, 1, 1, 16'h8001, NO_CAP);
    run_fill(-2048, 0, 2047, 1, 16'h7FFE, NO_CAP);

    // Single-pixel screen, then a zero-width one
    set_screen(REG_WIDTH, 1);
    set_screen(REG_HEIGHT, 1);
    run_fill(0, 0, 2047, 2047, 16'hF800, NO_CAP);
    run_fill(1, 0, 1, 1, 16'h001F, NO_CAP);
    set_screen(REG_WIDTH, 0);
    run_fill(0, 0, 1, 1, 16'hFFFF, NO_CAP);
    set_screen(REG_WIDTH, SCREEN_W_RST);
    set_screen(REG_HEIGHT, SCREEN_H_RST);

    // Long hold-off on the result side while pulls keep coming
    hold_req <= ~hold_req;
    run_fill(0, 0, 4, 2, 16'hF81F, NO_CAP);

    // Random fills under changing screen sizes and idling patterns
    base = items_sent;
    for (p = 0; p < 6; p++) begin
      send_idle_pct  = idle_send[p / 2];
      recv_stall_pct = idle_recv[p / 2];
      case (p)
        1: begin
          sw = 2047;
          sh = 2047;
        end
        3: begin
          sw = $urandom_range(1, 2047);
          sh = $urandom_range(1, 2047);
        end
        5: begin
          sw = SCREEN_W_RST;
          sh = SCREEN_H_RST;
        end
        default: begin
          sw = $urandom_range(1, 40);
          sh = $urandom_range(1, 30);
        end
      endcase
      set_screen(REG_WIDTH, sw);
      set_screen(REG_HEIGHT, sh);
      allow_noise = (sw * sh <= NOISE_AREA);
      while (items_sent - base < RANDOM_ITEMS * (p + 1) / 6) random_fill();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
